>>> hdl/lpa_pkg.sv
// shared types and constants for the light pattern animator
package lpa_pkg;

    localparam int NUM_PATTERNS_DEF    = 64;
    localparam int MAX_PATTERN_LEN_DEF = 64;
    localparam int QUEUE_DEPTH         = 4;

    localparam int OPCODE_W   = 2;
    localparam int PAT_FLD_W  = 6;
    localparam int POS_FLD_W  = 6;
    localparam int LEVEL_W    = 5;
    localparam int LEN_FLD_W  = 7;
    localparam int WHOLE_W    = 32;
    localparam int FRAC_W     = 8;
    localparam int BRIGHT_W   = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [BRIGHT_W-1:0] EMPTY_VALUE = 10'd264;
    localparam int                  LEVEL_SCALE = 22;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LEVEL  = 2'd0,
        OP_LENGTH = 2'd1,
        OP_TICK   = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERPOLATE = 1'b0,
        REG_FREEZE      = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_LEVEL,
        CMD_LENGTH,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [PAT_FLD_W-1:0]  pat;
        logic [POS_FLD_W-1:0]  pos;
        logic [LEVEL_W-1:0]    level;
        logic [LEN_FLD_W-1:0]  len;
        logic [WHOLE_W-1:0]    whole;
        logic [FRAC_W-1:0]     frac;
    } lpa_cmd_t;

    typedef struct packed {
        logic     valid;
        lpa_cmd_t cmd;
    } lpa_qword_t;

endpackage

>>> hdl/lpa_item_if.sv
// input item channel
interface lpa_item_if import lpa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [PAT_FLD_W-1:0] pattern_index;
    logic [POS_FLD_W-1:0] position;
    logic [LEVEL_W-1:0]   level;
    logic [LEN_FLD_W-1:0] pattern_length;
    logic [WHOLE_W-1:0]   time_whole;
    logic [FRAC_W-1:0]    time_fraction;

    modport source (output valid, opcode, pattern_index, position, level, pattern_length,
                    time_whole, time_fraction, input ready);
    modport sink   (input valid, opcode, pattern_index, position, level, pattern_length,
                    time_whole, time_fraction, output ready);
endinterface

>>> hdl/lpa_result_if.sv
// result channel
interface lpa_result_if import lpa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [PAT_FLD_W-1:0] result_pattern;
    logic [BRIGHT_W-1:0]  brightness;
    logic                 last_of_tick;

    modport source (output valid, result_pattern, brightness, last_of_tick, input ready);
    modport sink   (input valid, result_pattern, brightness, last_of_tick, output ready);
endinterface

>>> hdl/lpa_cfg_if.sv
// configuration write channel
interface lpa_cfg_if import lpa_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/lpa_ram.sv
// generic single write port ram with registered read
module lpa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/lpa_front.sv
// front end: accepts input words, drops unusable ones, forms commands
module lpa_front import lpa_pkg::*; #(
    parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    lpa_item_if.sink   item,
    input  logic       q_full,
    output lpa_qword_t push
);

    logic keep;

    assign item.ready = !q_full;

    always_comb
    begin
        keep           = 1'b0;
        push.cmd.kind  = CMD_TICK;
        push.cmd.pat   = item.pattern_index;
        push.cmd.pos   = item.position;
        push.cmd.level = item.level;
        push.cmd.len   = item.pattern_length;
        push.cmd.whole = item.time_whole;
        push.cmd.frac  = item.time_fraction;
        case (item.opcode)
            OP_LEVEL:
            begin
                push.cmd.kind = CMD_LEVEL;
                keep = (int'(item.pattern_index) < NUM_PATTERNS) &&
                       (int'(item.position) < MAX_PATTERN_LEN);
            end
            OP_LENGTH:
            begin
                push.cmd.kind = CMD_LENGTH;
                keep = int'(item.pattern_index) < NUM_PATTERNS;
            end
            OP_TICK:
            begin
                push.cmd.kind = CMD_TICK;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        push.valid = item.valid && item.ready && keep;
    end

endmodule

>>> hdl/lpa_queue.sv
// short command queue between front and back
module lpa_queue import lpa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  lpa_qword_t push,
    output logic       full,
    output lpa_qword_t head,
    input  logic       pop
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    lpa_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QW-1:0]     wr_ptr_reg;
    logic [QW-1:0]     rd_ptr_reg;
    logic [QW:0]       count_reg;
    logic [QW:0]       count_next;
    logic              do_pop;

    assign full       = (count_reg == (QW+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("queue written while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a word");

endmodule

>>> hdl/lpa_back.sv
// back end: runs writes and walks all patterns on a tick
module lpa_back import lpa_pkg::*; #(
    parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  lpa_qword_t head,
    output logic       pop,
    lpa_result_if.source result,
    lpa_cfg_if.sink      cfg
);

    localparam int PW        = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int LEN_W     = $clog2(MAX_PATTERN_LEN + 1);
    localparam int IW        = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LVL_DEPTH = NUM_PATTERNS * MAX_PATTERN_LEN;
    localparam int LVL_AW    = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;
    localparam int BLEND_W   = LEVEL_W + FRAC_W + 1;
    localparam int SCALE_W   = BLEND_W + 5;
    localparam int BIT_W     = $clog2(WHOLE_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDLEN,
        S_CHK,
        S_MOD,
        S_RDA,
        S_RDB,
        S_MUL,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic [PW-1:0]         pat_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [WHOLE_W-1:0]    whole_reg;
    logic [WHOLE_W-1:0]    div_reg;
    logic [FRAC_W-1:0]     frac_reg;
    logic [LEN_W-1:0]      rem_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [IW-1:0]         a_idx_reg;
    logic [IW-1:0]         b_idx_reg;
    logic [LEVEL_W-1:0]    a_lev_reg;
    logic [BLEND_W-1:0]    blend_reg;
    logic [BRIGHT_W-1:0]   val_reg;
    logic                  interp_reg;
    logic                  freeze_reg;
    logic [NUM_PATTERNS-1:0] len_vld_reg;
    logic [NUM_PATTERNS-1:0] held_vld_reg;
    logic                  out_valid_reg;
    logic [PAT_FLD_W-1:0]  out_pat_reg;
    logic [BRIGHT_W-1:0]   out_val_reg;
    logic                  out_last_reg;

    logic                  lvl_we;
    logic [LVL_AW-1:0]     lvl_waddr;
    logic [LVL_AW-1:0]     lvl_raddr;
    logic [LEVEL_W-1:0]    lvl_rd;
    logic                  len_we;
    logic [PW-1:0]         q_pat;
    logic [LEN_W-1:0]      len_wdata;
    logic [LEN_W-1:0]      len_rd;
    logic                  held_we;
    logic [BRIGHT_W-1:0]   held_rd;
    logic [LEN_W-1:0]      len_now;
    logic [BRIGHT_W-1:0]   held_now;
    logic [LEN_W:0]        rem_sh;
    logic [LEN_W-1:0]      rem_next;
    logic [LEN_W-1:0]      rem_inc;
    logic [LEN_W-1:0]      b_rem;
    logic [BLEND_W-1:0]    prod_a;
    logic [BLEND_W-1:0]    prod_b;
    logic [BLEND_W-1:0]    blend_next;
    logic [SCALE_W-1:0]    scaled;
    logic [BRIGHT_W-1:0]   emit_val;
    logic                  emit_go;
    logic                  last_pat;

    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.result_pattern = out_pat_reg;
    assign result.brightness     = out_val_reg;
    assign result.last_of_tick   = out_last_reg;

    assign q_pat    = PW'(head.cmd.pat);
    assign pop      = (state_reg == S_IDLE) && head.valid;
    assign lvl_we   = pop && (head.cmd.kind == CMD_LEVEL);
    assign len_we   = pop && (head.cmd.kind == CMD_LENGTH);
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);
    assign held_we  = emit_go && !freeze_reg;
    assign last_pat = (pat_reg == PW'(NUM_PATTERNS - 1));
    assign emit_val = (!freeze_reg && len_reg != '0) ? scaled[FRAC_W +: BRIGHT_W] : val_reg;

    always_comb
    begin
        lvl_waddr = LVL_AW'(LVL_AW'(head.cmd.pat) * LVL_AW'(MAX_PATTERN_LEN)
                            + LVL_AW'(head.cmd.pos));
        lvl_raddr = LVL_AW'(LVL_AW'(pat_reg) * LVL_AW'(MAX_PATTERN_LEN)
                            + LVL_AW'((state_reg == S_RDA) ? a_idx_reg : b_idx_reg));
        len_wdata = (int'(head.cmd.len) > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN)
                                                          : LEN_W'(head.cmd.len);
        len_now   = len_vld_reg[pat_reg] ? len_rd : '0;
        held_now  = held_vld_reg[pat_reg] ? held_rd : EMPTY_VALUE;

        // one restoring remainder step per cycle
        rem_sh    = {rem_reg, div_reg[WHOLE_W-1]};
        rem_next  = (rem_sh >= {1'b0, len_reg}) ? LEN_W'(rem_sh - {1'b0, len_reg})
                                                : LEN_W'(rem_sh);
        rem_inc   = rem_next + 1'b1;
        b_rem     = (frac_reg == '0)     ? rem_next :
                    (rem_inc == len_reg) ? '0 : rem_inc;

        prod_a    = BLEND_W'(a_lev_reg) * (BLEND_W'(1 << FRAC_W) - BLEND_W'(frac_reg));
        prod_b    = BLEND_W'(lvl_rd) * BLEND_W'(frac_reg);
        blend_next = interp_reg ? BLEND_W'(prod_a + prod_b)
                                : BLEND_W'({a_lev_reg, {FRAC_W{1'b0}}});
        scaled    = SCALE_W'(blend_reg) * SCALE_W'(LEVEL_SCALE);
    end

    lpa_ram #(.WIDTH(LEVEL_W), .DEPTH(LVL_DEPTH)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (head.cmd.level),
        .raddr (lvl_raddr),
        .rdata (lvl_rd)
    );

    lpa_ram #(.WIDTH(LEN_W), .DEPTH(NUM_PATTERNS)) u_length_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (q_pat),
        .wdata (len_wdata),
        .raddr (pat_reg),
        .rdata (len_rd)
    );

    lpa_ram #(.WIDTH(BRIGHT_W), .DEPTH(NUM_PATTERNS)) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (pat_reg),
        .wdata (emit_val),
        .raddr (pat_reg),
        .rdata (held_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pat_reg       <= '0;
            len_reg       <= '0;
            whole_reg     <= '0;
            div_reg       <= '0;
            frac_reg      <= '0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            a_idx_reg     <= '0;
            b_idx_reg     <= '0;
            a_lev_reg     <= '0;
            blend_reg     <= '0;
            val_reg       <= EMPTY_VALUE;
            interp_reg    <= 1'b1;
            freeze_reg    <= 1'b0;
            len_vld_reg   <= '0;
            held_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_pat_reg   <= '0;
            out_val_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_INTERPOLATE: interp_reg <= cfg.data[0];
                    REG_FREEZE:      freeze_reg <= cfg.data[0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && result.ready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (head.cmd.kind == CMD_LENGTH)
                        begin
                            len_vld_reg[q_pat] <= 1'b1;
                        end
                        if (head.cmd.kind == CMD_TICK)
                        begin
                            whole_reg <= head.cmd.whole;
                            frac_reg  <= head.cmd.frac;
                            pat_reg   <= '0;
                            state_reg <= S_RDLEN;
                        end
                    end
                end
                S_RDLEN:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    len_reg <= len_now;
                    div_reg <= whole_reg;
                    rem_reg <= '0;
                    bit_reg <= BIT_W'(WHOLE_W - 1);
                    if (freeze_reg)
                    begin
                        val_reg   <= held_now;
                        state_reg <= S_EMIT;
                    end
                    else if (len_now == '0)
                    begin
                        val_reg   <= EMPTY_VALUE;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    rem_reg <= rem_next;
                    div_reg <= {div_reg[WHOLE_W-2:0], 1'b0};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        a_idx_reg <= IW'(rem_next);
                        b_idx_reg <= IW'(b_rem);
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    a_lev_reg <= lvl_rd;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    blend_reg <= blend_next;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pat_reg   <= PAT_FLD_W'(pat_reg);
                        out_val_reg   <= emit_val;
                        out_last_reg  <= last_pat;
                        if (!freeze_reg)
                        begin
                            held_vld_reg[pat_reg] <= 1'b1;
                        end
                        if (last_pat)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pat_reg   <= pat_reg + 1'b1;
                            state_reg <= S_RDLEN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (out_last_reg == (out_pat_reg == PAT_FLD_W'(NUM_PATTERNS - 1))))
        else $error("last flag not on final pattern");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDA) |-> (len_reg != '0))
        else $error("level read for empty pattern");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDA) |-> ((LEN_W+1)'(a_idx_reg) < (LEN_W+1)'(len_reg) &&
                                  (LEN_W+1)'(b_idx_reg) < (LEN_W+1)'(len_reg)))
        else $error("frame index beyond pattern length");

    a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (head.valid && state_reg != S_IDLE) |-> !pop)
        else $error("command taken during a tick walk");

endmodule

>>> hdl/light_pattern_animator.sv
// top level of the light pattern animator
// a level or length write is held in the queue and reaches its store when the idle back end pops it
// a tick leaves the queue, then each pattern goes through S_RDLEN, S_CHK, S_MOD, S_RDA, S_RDB,
// S_MUL and S_EMIT, with S_MOD taking one remainder step for each bit of the whole time;
// with freeze on, or for an empty pattern, a pattern goes from S_CHK straight to S_EMIT; result stalls hold S_EMIT
// reset: interpolation on, freeze off, all lengths zero, all held values 264; level store kept
module light_pattern_animator import lpa_pkg::*; #(
    parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lpa_item_if.sink      item,
    lpa_result_if.source  result,
    lpa_cfg_if.sink       cfg
);

    lpa_qword_t push;
    lpa_qword_t head;
    logic       q_full;
    logic       pop;

    lpa_front #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_front (
        .item   (item),
        .q_full (q_full),
        .push   (push)
    );

    lpa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    lpa_back #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result),
        .cfg    (cfg)
    );

endmodule

>>> verif/light_pattern_animator_checker.sv
`timescale 1ns / 1ps
// checker for the light pattern animator: predicts each tick's brightness words and compares
module light_pattern_animator_checker import lpa_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    lpa_item_if   item,
    lpa_result_if result,
    lpa_cfg_if    cfg,
    output int    due_count,
    output int    fail_count
);

    typedef struct {
        logic [PAT_FLD_W-1:0] pat;
        logic [BRIGHT_W-1:0]  value;
        logic                 last;
    } lamp_word_t;

    logic [LEVEL_W-1:0]   lvl_shadow [NUM_PATTERNS_DEF][MAX_PATTERN_LEN_DEF];
    logic [LEN_FLD_W-1:0] len_shadow [NUM_PATTERNS_DEF];
    logic [BRIGHT_W-1:0]  shown_value [NUM_PATTERNS_DEF];
    logic                 blend_on;
    logic                 hold_on;
    lamp_word_t           brightness_due [$];
    int                   mismatches = 0;

    function automatic logic [BRIGHT_W-1:0] pattern_brightness(int p,
                                                               logic [WHOLE_W-1:0] whole,
                                                               logic [FRAC_W-1:0] frac);
        int unsigned n;
        int unsigned f;
        int unsigned a_pos;
        int unsigned b_pos;
        int unsigned a;
        int unsigned b;
        int unsigned v;
        n = len_shadow[p];
        f = frac;
        if (n == 0)
            v = EMPTY_VALUE;
        else if (n == 1)
            v = LEVEL_SCALE * lvl_shadow[p][0];
        else
        begin
            a_pos = whole % n;
            a = lvl_shadow[p][a_pos];
            if (!blend_on)
                v = LEVEL_SCALE * a;
            else
            begin
                // next frame index is taken over 33 bits so the maximum whole does not wrap
                if (f != 0)
                    b_pos = 32'(({1'b0, whole} + 33'd1) % n);
                else
                    b_pos = a_pos;
                b = lvl_shadow[p][b_pos];
                v = (LEVEL_SCALE * a * (256 - f) + LEVEL_SCALE * b * f) >> 8;
            end
        end
        return v[BRIGHT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lamp_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PATTERNS_DEF; i++)
            begin
                len_shadow[i] = '0;
                shown_value[i] = EMPTY_VALUE;
                for (int k = 0; k < MAX_PATTERN_LEN_DEF; k++)
                    lvl_shadow[i][k] = '0;
            end
            blend_on = 1'b1;
            hold_on = 1'b0;
            brightness_due.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_INTERPOLATE: blend_on = cfg.data;
                    REG_FREEZE:      hold_on = cfg.data;
                    default:         ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (brightness_due.size() == 0)
                begin
                    $error("word for pattern %0d with nothing expected", result.result_pattern);
                    mismatches++;
                end
                else
                begin
                    want = brightness_due.pop_front();
                    if (result.result_pattern !== want.pat)
                    begin
                        $error("result_pattern: expected %0d, got %0d", want.pat,
                               result.result_pattern);
                        mismatches++;
                    end
                    if (result.brightness !== want.value)
                    begin
                        $error("brightness: expected %0d, got %0d", want.value,
                               result.brightness);
                        mismatches++;
                    end
                    if (result.last_of_tick !== want.last)
                    begin
                        $error("last_of_tick: expected %0d, got %0d", want.last,
                               result.last_of_tick);
                        mismatches++;
                    end
                end
            end

            if (item.valid && item.ready)
            begin
                case (item.opcode)
                    OP_LEVEL:
                        lvl_shadow[item.pattern_index][item.position] = item.level;
                    OP_LENGTH:
                        if (item.pattern_length > MAX_PATTERN_LEN_DEF)
                            len_shadow[item.pattern_index] = LEN_FLD_W'(MAX_PATTERN_LEN_DEF);
                        else
                            len_shadow[item.pattern_index] = item.pattern_length;
                    OP_TICK:
                        for (int i = 0; i < NUM_PATTERNS_DEF; i++)
                        begin
                            if (!hold_on)
                                shown_value[i] = pattern_brightness(i, item.time_whole,
                                                                    item.time_fraction);
                            want.pat = PAT_FLD_W'(i);
                            want.value = shown_value[i];
                            want.last = (i == NUM_PATTERNS_DEF - 1);
                            brightness_due.push_back(want);
                        end
                    default:
                        ;
                endcase
            end
        end
        due_count <= brightness_due.size();
        fail_count <= mismatches;
    end

endmodule

>>> verif/light_pattern_animator_tb.sv
`timescale 1ns / 1ps
// testbench top for the light pattern animator: clock, reset, stimulus and verdict
module light_pattern_animator_tb;
    import lpa_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS   = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 2500;
    localparam int STALL_LIMIT   = 20000;

    logic clk;
    logic rst_n;
    int   due_count;
    int   fail_count;
    int   idle_cycles = 0;
    int   sent = 0;
    bit   steady = 1'b0;
    bit   hold_req = 1'b0;
    bit   hold_served = 1'b0;
    bit   [MAX_PATTERN_LEN_DEF-1:0] filled [NUM_PATTERNS_DEF];
    int   shaped_len [NUM_PATTERNS_DEF];

    lpa_item_if   item_ch ();
    lpa_result_if res_ch ();
    lpa_cfg_if    cfg_ch ();

    light_pattern_animator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    light_pattern_animator_checker brightness_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .due_count  (due_count),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [WHOLE_W-1:0] pick_whole();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll < 5)
            return $urandom_range(0, 300);
        return $urandom;
    endfunction

    function automatic logic [FRAC_W-1:0] pick_frac();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 3)
            return '0;
        if (roll < 5)
            return '1;
        return FRAC_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        if (roll < 25)
            return 1;
        if (roll < 85)
            return $urandom_range(2, 6);
        return $urandom_range(7, 16);
    endfunction

    // valid stays high into the next word when there is no gap
    task automatic send_item(logic [OPCODE_W-1:0] op, logic [PAT_FLD_W-1:0] pat,
                             logic [POS_FLD_W-1:0] pos, logic [LEVEL_W-1:0] lev,
                             logic [LEN_FLD_W-1:0] len, logic [WHOLE_W-1:0] whole,
                             logic [FRAC_W-1:0] frac);
        int gap;
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= op;
        item_ch.pattern_index  <= pat;
        item_ch.position       <= pos;
        item_ch.level          <= lev;
        item_ch.pattern_length <= len;
        item_ch.time_whole     <= whole;
        item_ch.time_fraction  <= frac;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_level(int p, int pos, int lev);
        send_item(OP_LEVEL, PAT_FLD_W'(p), POS_FLD_W'(pos), LEVEL_W'(lev),
                  LEN_FLD_W'($urandom), $urandom, FRAC_W'($urandom));
        filled[p][pos] = 1'b1;
    endtask

    task automatic put_length(int p, int n);
        send_item(OP_LENGTH, PAT_FLD_W'(p), POS_FLD_W'($urandom), LEVEL_W'($urandom),
                  LEN_FLD_W'(n), $urandom, FRAC_W'($urandom));
        shaped_len[p] = (n > MAX_PATTERN_LEN_DEF) ? MAX_PATTERN_LEN_DEF : n;
    endtask

    task automatic tick(logic [WHOLE_W-1:0] whole, logic [FRAC_W-1:0] frac);
        send_item(OP_TICK, PAT_FLD_W'($urandom), POS_FLD_W'($urandom), LEVEL_W'($urandom),
                  LEN_FLD_W'($urandom), whole, frac);
    endtask

    task automatic junk();
        send_item(OP_UNUSED, PAT_FLD_W'($urandom), POS_FLD_W'($urandom), LEVEL_W'($urandom),
                  LEN_FLD_W'($urandom), $urandom, FRAC_W'($urandom));
    endtask

    // every level inside the new length is written before the length itself
    task automatic shape_pattern(int p, int n);
        int span;
        span = (n > MAX_PATTERN_LEN_DEF) ? MAX_PATTERN_LEN_DEF : n;
        for (int k = 0; k < span; k++)
            if (!filled[p][k])
                put_level(p, k, $urandom_range(0, 31));
        put_length(p, n);
    endtask

    task automatic drain_and_settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(bit blend, bit hold);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_INTERPOLATE;
        cfg_ch.data  <= blend;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= REG_FREEZE;
        cfg_ch.data  <= hold;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int quota);
        int stop;
        int roll;
        int p;
        int keep;
        stop = sent + quota;
        while (sent < stop)
        begin
            roll = $urandom_range(0, 99);
            p = $urandom_range(0, NUM_PATTERNS_DEF - 1);
            if (roll < 35)
                tick(pick_whole(), pick_frac());
            else if (roll < 75)
                shape_pattern(p, pick_len());
            else if (roll < 87)
                put_level(p, $urandom_range(0, MAX_PATTERN_LEN_DEF - 1), $urandom_range(0, 31));
            else if (roll < 93)
                junk();
            else
            begin
                // a stray length, put right before any tick can use it
                keep = shaped_len[p];
                put_length(p, $urandom_range(0, 127));
                put_length(p, keep);
            end
        end
    endtask

    initial
    begin : result_drain
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = steady ? 0 : pick_gap();
                if (stall > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.opcode         <= OP_LEVEL;
        item_ch.pattern_index  <= '0;
        item_ch.position       <= '0;
        item_ch.level          <= '0;
        item_ch.pattern_length <= '0;
        item_ch.time_whole     <= '0;
        item_ch.time_fraction  <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_INTERPOLATE;
        cfg_ch.data            <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_mode(1'b1, 1'b0);

        // all patterns empty after reset
        tick('0, '0);
        // one-level pattern with a level above 25
        put_level(0, 0, 31);
        put_length(0, 1);
        put_level(63, 0, 25);
        put_level(63, 1, 0);
        put_level(63, 2, 16);
        put_length(63, 3);
        put_level(1, 0, 7);
        put_level(1, 1, 20);
        put_length(1, 2);
        // whole at maximum, next frame index without wrap
        tick('1, '1);
        tick(5, '0);
        tick(7, 128);
        junk();
        // saturating length, cleared before any tick
        put_length(2, 127);
        put_length(2, 0);
        put_length(3, 0);

        drain_and_settle();
        set_mode(1'b1, 1'b0);
        shape_pattern($urandom_range(0, NUM_PATTERNS_DEF - 1), $urandom_range(64, 127));
        tick(pick_whole(), pick_frac());
        run_phase(PHASE_ITEMS);

        // results held off while words keep coming
        drain_and_settle();
        set_mode(1'b0, 1'b0);
        hold_req = 1'b1;
        steady = 1'b1;
        tick(pick_whole(), pick_frac());
        run_phase(PHASE_ITEMS);
        steady = 1'b0;

        drain_and_settle();
        set_mode(1'b1, 1'b1);
        run_phase(PHASE_ITEMS);

        drain_and_settle();
        set_mode(1'b0, 1'b1);
        run_phase(PHASE_ITEMS);

        drain_and_settle();
        set_mode(1'b1, 1'b0);
        run_phase(PHASE_ITEMS);

        drain_and_settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
